/* rtl/cbpa_pkg.sv */
package cbpa_pkg;

  // Pool geometry
  localparam int CHUNK_SLOTS = 8;
  localparam int BLOCKS_MAX  = 256;

  // Width of the available counter, which saturates at all ones
  localparam int AVAIL_W = 16;
  localparam logic [AVAIL_W-1:0] AVAIL_MAX = '1;

  // Configuration register indexes
  localparam logic CFG_FIRST_BLOCKS = 1'b0;
  localparam logic CFG_GROW_BLOCKS  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_NO_SLOT   = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_SCAN,
    ST_MAKE,
    ST_FILL,
    ST_TAKE,
    ST_TAKE_RD,
    ST_FREE,
    ST_FIND,
    ST_RET,
    ST_FRONT,
    ST_RELEASE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    ALU_NOP,
    ALU_INC,
    ALU_DEC,
    ALU_LT
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic [AVAIL_W-1:0] a;
    logic [AVAIL_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [AVAIL_W-1:0] res;
    logic               flag;
  } alu_rsp_t;

  typedef struct packed {
    status_t    status;
    logic [2:0] chunk;
    logic [7:0] index;
  } result_t;

endpackage

/* rtl/cbpa_alu.sv */
module cbpa_alu import cbpa_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [AVAIL_W-1:0] inc;

  // Saturating increment shared by all counting steps
  assign inc = (req.a == AVAIL_MAX) ? req.a : req.a + AVAIL_W'(1);

  // Increment with end compare, decrement, or less-than
  always_comb begin
    rsp = '0;
    unique case (req.op)
      ALU_INC: begin
        rsp.res  = inc;
        rsp.flag = (inc == req.b);
      end
      ALU_DEC: begin
        rsp.res  = req.a - AVAIL_W'(1);
        rsp.flag = 1'b0;
      end
      ALU_LT: begin
        rsp.res  = req.a;
        rsp.flag = (req.a < req.b);
      end
      default: begin
        rsp = '0;
      end
    endcase
  end

endmodule

/* rtl/cbpa_link_ram.sv */
module cbpa_link_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write one link, read one link with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/cbpa_seq.sv */
module cbpa_seq import cbpa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [8:0] first_blocks,
  input  logic [8:0] grow_blocks,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [2:0] free_chunk,
  input  logic [7:0] free_index,
  output logic       res_valid,
  input  logic       res_ready,
  output result_t    res
);

  localparam int SW     = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1;
  localparam int CW     = $clog2(CHUNK_SLOTS + 1);
  localparam int IW     = $clog2(BLOCKS_MAX);
  localparam int ZW     = $clog2(BLOCKS_MAX + 1);
  localparam int DEPTH  = CHUNK_SLOTS * BLOCKS_MAX;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SECOND = (CHUNK_SLOTS > 1) ? 1 : 0;

  state_t state, state_next;

  // Per-slot tables and chunk order list
  logic [CHUNK_SLOTS-1:0] in_use;
  logic [ZW-1:0]          blk_count [CHUNK_SLOTS];
  logic [AVAIL_W-1:0]     avail     [CHUNK_SLOTS];
  logic [IW-1:0]          first_free[CHUNK_SLOTS];
  logic [SW-1:0]          order     [CHUNK_SLOTS];
  logic [CW-1:0]          chunk_count;

  // Item context
  logic [2:0]    fchunk;
  logic [7:0]    fidx;
  logic [SW-1:0] p;
  logic [SW-1:0] cur;
  logic [ZW-1:0] mk_size;
  logic          mk_grow;
  logic [IW-1:0] fill_i;

  logic [SW-1:0]      fslot;
  logic [IW-1:0]      fidx_iw;
  logic               fslot_ok;
  logic [SW-1:0]      rd_slot;
  logic [AVAIL_W-1:0] rd_avail;
  logic               free_found;
  logic [SW-1:0]      free_slot;
  logic [ZW-1:0]      first_size;
  logic [ZW-1:0]      grow_size;
  logic               make_ok;
  logic               release_ok;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic          mem_we;
  logic [SW-1:0] addr_slot;
  logic [IW-1:0] addr_idx;
  logic [AW-1:0] mem_addr;
  logic [IW-1:0] mem_wdata;
  logic [IW-1:0] mem_rdata;

  cbpa_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  cbpa_link_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (IW)
  ) u_link (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  // Clamp the configured sizes to the chunk capacity
  assign first_size = (32'(first_blocks) > BLOCKS_MAX) ? ZW'(BLOCKS_MAX) : ZW'(first_blocks);
  assign grow_size  = (32'(grow_blocks) > BLOCKS_MAX) ? ZW'(BLOCKS_MAX) : ZW'(grow_blocks);

  assign fslot    = SW'(fchunk);
  assign fidx_iw  = IW'(fidx);
  assign fslot_ok = (32'(fchunk) < CHUNK_SLOTS);
  assign mem_addr = AW'(32'(addr_slot) * BLOCKS_MAX + 32'(addr_idx));
  assign make_ok  = free_found && (32'(chunk_count) < CHUNK_SLOTS);

  // Find the lowest unused slot
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = CHUNK_SLOTS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_slot  = SW'(i);
      end
    end
  end

  // Select the single slot that the tables are read at
  always_comb begin
    rd_slot = cur;
    case (state) inside
      ST_SCAN, ST_FIND:        rd_slot = order[p];
      ST_FREE, ST_RET:         rd_slot = fslot;
      ST_RELEASE:              rd_slot = order[SECOND];
      default:                 rd_slot = cur;
    endcase
  end
  assign rd_avail   = avail[rd_slot];
  assign release_ok = (chunk_count > CW'(1)) && (rd_avail != '0);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = action ? ST_FREE : ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        state_next = (chunk_count == '0) ? ST_MAKE : ST_SCAN;
      end
      ST_SCAN: begin
        if (rd_avail != '0) begin
          state_next = ST_TAKE;
        end else if (alu_rsp.flag) begin
          state_next = (grow_blocks == '0) ? ST_DONE : ST_MAKE;
        end
      end
      ST_MAKE: begin
        if (!make_ok) begin
          state_next = ST_DONE;
        end else if (mk_size != '0) begin
          state_next = ST_FILL;
        end else begin
          state_next = mk_grow ? ST_TAKE : ST_SCAN;
        end
      end
      ST_FILL: begin
        if (alu_rsp.flag) begin
          state_next = mk_grow ? ST_TAKE : ST_SCAN;
        end
      end
      ST_TAKE:    state_next = ST_TAKE_RD;
      ST_TAKE_RD: state_next = ST_DONE;
      ST_FREE: begin
        state_next = (fslot_ok && in_use[fslot] && alu_rsp.flag) ? ST_FIND : ST_DONE;
      end
      ST_FIND: begin
        if (rd_slot == fslot) begin
          state_next = ST_RET;
        end else if (alu_rsp.flag) begin
          state_next = ST_DONE;
        end
      end
      ST_RET:     state_next = alu_rsp.flag ? ST_FRONT : ST_DONE;
      ST_FRONT:   state_next = ST_RELEASE;
      ST_RELEASE: state_next = ST_DONE;
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // Outputs: shared unit request, link port, handshake
  always_comb begin
    alu_req   = '0;
    mem_we    = 1'b0;
    addr_slot = cur;
    addr_idx  = fill_i;
    mem_wdata = '0;
    unique case (state) inside
      ST_SCAN, ST_FIND: begin
        alu_req.op = ALU_INC;
        alu_req.a  = AVAIL_W'(p);
        alu_req.b  = AVAIL_W'(chunk_count);
      end
      ST_FILL: begin
        alu_req.op = ALU_INC;
        alu_req.a  = AVAIL_W'(fill_i);
        alu_req.b  = AVAIL_W'(mk_size);
        mem_we     = 1'b1;
        mem_wdata  = alu_rsp.flag ? '0 : IW'(alu_rsp.res);
      end
      ST_TAKE: begin
        addr_idx = first_free[cur];
      end
      ST_TAKE_RD: begin
        alu_req.op = ALU_DEC;
        alu_req.a  = avail[cur];
      end
      ST_FREE: begin
        alu_req.op = ALU_LT;
        alu_req.a  = AVAIL_W'(fidx);
        alu_req.b  = AVAIL_W'(blk_count[fslot]);
      end
      ST_RET: begin
        alu_req.op = ALU_INC;
        alu_req.a  = avail[fslot];
        alu_req.b  = AVAIL_W'(blk_count[fslot]);
        mem_we     = 1'b1;
        addr_slot  = fslot;
        addr_idx   = fidx_iw;
        mem_wdata  = first_free[fslot];
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  assign in_stall  = (state != ST_IDLE);
  assign res_valid = (state == ST_DONE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control tables
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use      <= '0;
      chunk_count <= '0;
      for (int i = 0; i < CHUNK_SLOTS; i++) begin
        blk_count[i]  <= '0;
        avail[i]      <= '0;
        first_free[i] <= '0;
      end
    end else begin
      case (state)
        ST_MAKE: begin
          if (make_ok) begin
            in_use[free_slot]     <= 1'b1;
            blk_count[free_slot]  <= mk_size;
            avail[free_slot]      <= AVAIL_W'(mk_size);
            first_free[free_slot] <= '0;
            chunk_count           <= chunk_count + CW'(1);
          end
        end
        ST_TAKE_RD: begin
          first_free[cur] <= mem_rdata;
          avail[cur]      <= alu_rsp.res;
        end
        ST_RET: begin
          first_free[fslot] <= fidx_iw;
          avail[fslot]      <= alu_rsp.res;
        end
        ST_RELEASE: begin
          if (release_ok) begin
            chunk_count       <= chunk_count - CW'(1);
            in_use[fslot]     <= 1'b0;
            blk_count[fslot]  <= '0;
            avail[fslot]      <= '0;
            first_free[fslot] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Order list and item context
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          fchunk     <= free_chunk;
          fidx       <= free_index;
          res.status <= STAT_OK;
          res.chunk  <= '0;
          res.index  <= '0;
        end
      end
      ST_ALLOC: begin
        p       <= '0;
        mk_size <= first_size;
        mk_grow <= 1'b0;
      end
      ST_SCAN: begin
        if (rd_avail != '0) begin
          cur <= rd_slot;
        end else if (alu_rsp.flag) begin
          mk_size <= grow_size;
          mk_grow <= 1'b1;
          if (grow_blocks == '0) begin
            res.status <= STAT_EXHAUSTED;
          end
        end else begin
          p <= SW'(alu_rsp.res);
        end
      end
      ST_MAKE: begin
        p      <= '0;
        fill_i <= '0;
        cur    <= free_slot;
        if (make_ok) begin
          for (int i = 1; i < CHUNK_SLOTS; i++) begin
            order[i] <= order[i-1];
          end
          order[0] <= free_slot;
        end else begin
          res.status <= STAT_NO_SLOT;
        end
      end
      ST_FILL: begin
        fill_i <= IW'(alu_rsp.res);
      end
      ST_TAKE_RD: begin
        res.chunk <= 3'(cur);
        res.index <= 8'(first_free[cur]);
      end
      ST_FREE: begin
        p <= '0;
        if (!(fslot_ok && in_use[fslot] && alu_rsp.flag)) begin
          res.status <= STAT_NOT_FOUND;
        end
      end
      ST_FIND: begin
        if (rd_slot != fslot) begin
          if (alu_rsp.flag) begin
            res.status <= STAT_NOT_FOUND;
          end else begin
            p <= SW'(alu_rsp.res);
          end
        end
      end
      ST_FRONT: begin
        for (int i = 1; i < CHUNK_SLOTS; i++) begin
          if (i <= int'(p)) begin
            order[i] <= order[i-1];
          end
        end
        order[0] <= fslot;
      end
      ST_RELEASE: begin
        if (release_ok) begin
          for (int i = 0; i < CHUNK_SLOTS - 1; i++) begin
            order[i] <= order[i+1];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Slot bookkeeping stays consistent
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    32'(chunk_count) <= CHUNK_SLOTS)
    else $error("chunk count beyond slot count");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(in_use) == 32'(chunk_count))
    else $error("chunk count differs from slots in use");

  a_take_has_block: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TAKE_RD) |-> (avail[cur] != '0))
    else $error("block taken from a chunk with none available");

  a_release_after_front: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RELEASE) |-> ($past(state) == ST_FRONT))
    else $error("release entered without moving chunk to front");

endmodule

/* rtl/chunked_block_pool_allocator.sv */
// Channel  | Dir | Handshake          | Payload
// cfg      | in  | cfg_we             | cfg_index, cfg_data
// in       | in  | in_valid/in_stall  | action, free_chunk, free_index
// out      | out | out_valid/out_stall| status, given_chunk, given_index
//
// One item at a time; the next item is taken once the result reaches the output register.
// Allocate: scans the order list chunk by chunk, then takes the first free block; creating a chunk
// first writes its link chain block by block through the single link memory port.
// Free: searches the order list and returns the block; an emptied chunk moves to the front and may be released.
// Synchronous reset clears slot tables and chunk count; the link memory is not cleared.
// A stalled result holds in the output register while the next item is worked on.
module chunked_block_pool_allocator import cbpa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [2:0] free_chunk,
  input  logic [7:0] free_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [2:0] given_chunk,
  output logic [7:0] given_index
);

  logic [8:0] first_blocks;
  logic [8:0] grow_blocks;
  logic       res_valid;
  logic       res_ready;
  result_t    res;
  result_t    out_res;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_blocks <= 9'd64;
      grow_blocks  <= 9'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_BLOCKS: first_blocks <= cfg_data;
        CFG_GROW_BLOCKS:  grow_blocks  <= cfg_data;
        default:          first_blocks <= first_blocks;
      endcase
    end
  end

  cbpa_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .first_blocks (first_blocks),
    .grow_blocks  (grow_blocks),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .free_chunk   (free_chunk),
    .free_index   (free_index),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // Load the output register when it is empty or being drained
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign status      = out_res.status;
  assign given_chunk = out_res.chunk;
  assign given_index = out_res.index;

  // Output transaction never drops while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_res)))
    else $error("stalled result changed");

endmodule
